/* rtl/core/fwdr_pkg.sv */
// Shared types and constants for the FIFO with delete and reverse.
`default_nettype none

package fwdr_pkg;

    localparam int DEPTH_DEF = 16;  // default number of entries
    localparam int REQ_W     = 3;   // request code width
    localparam int VAL_W     = 32;  // entry width
    localparam int STS_W     = 2;   // status width
    localparam int CNT_W     = 5;   // width of the reported counts

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQ  = 3'd0,
        REQ_DEQ  = 3'd1,
        REQ_DEL  = 3'd2,
        REQ_REV  = 3'd3,
        REQ_READ = 3'd4
    } t_req;

    typedef enum logic [STS_W-1:0] {
        STS_OK       = 2'd0,
        STS_EMPTY    = 2'd1,
        STS_FULL     = 2'd2,
        STS_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DQ,
        ST_SCAN,
        ST_SHIFT,
        ST_RV_RB,
        ST_RV_WA,
        ST_RV_WB,
        ST_RO_RD,
        ST_RO_EMIT,
        ST_RESP
    } t_state;

endpackage

`default_nettype wire

/* rtl/core/fwdr_if.sv */
// Valid/ready channels for requests and results.
`default_nettype none

interface fwdr_req_if;
    import fwdr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [REQ_W-1:0]        req_type;
    logic signed [VAL_W-1:0] data_value;

    modport source (output valid, output req_type, output data_value, input ready);
    modport sink   (input valid, input req_type, input data_value, output ready);
endinterface

interface fwdr_rsp_if;
    import fwdr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] out_value;
    logic                    is_even;
    logic [STS_W-1:0]        status;
    logic [CNT_W-1:0]        occupancy;
    logic [CNT_W-1:0]        even_count;
    logic                    last;

    modport source (output valid, output out_value, output is_even, output status,
                    output occupancy, output even_count, output last, input ready);
    modport sink   (input valid, input out_value, input is_even, input status,
                    input occupancy, input even_count, input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/fifo_with_delete_and_reverse.sv */
// Top level of the bounded FIFO with delete-by-value, reverse and read-out.
//
// A circular queue of DEPTH signed 32-bit words kept in one synchronous RAM
// (one write and one read per cycle, registered read data). Requests arrive
// on i_req and are handled one at a time; results leave on o_rsp through an
// output register, so the next request is taken while a result still waits.
// Reverse swaps one pair of words at a time, read-out reads one word at a time
// and waits while the output register is full, and delete is a scan that
// compares one word per cycle, then a shift that moves one word per cycle.
// The single RAM read port paces these steps. Every result
// reports the occupancy and the count of even words after the request; a
// read-out marks its final word with last. Errors (dequeue or read-out of an
// empty queue, enqueue into a full one, delete of an absent value) give a
// status code and leave the queue untouched. No clearing pass follows reset.
`default_nettype none

module fifo_with_delete_and_reverse #(
    parameter int DEPTH = fwdr_pkg::DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fwdr_req_if.sink   i_req,
    fwdr_rsp_if.source o_rsp
);
    import fwdr_pkg::*;

    localparam int AW = $clog2(DEPTH);       // RAM address width
    localparam int CW = $clog2(DEPTH + 1);   // count width, holds DEPTH itself

    // ring position of the k-th word from the head; sum stays below 2*DEPTH
    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] head,
                                             input logic [CW-1:0] k);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(k);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // control state
    t_state  r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_even, n_even;
    logic [CW-1:0] r_idx, n_idx;     // walk index
    logic          r_pend, n_pend;   // a RAM read is in flight

    // request payload and pending result
    logic [VAL_W-1:0] r_val, n_val;
    logic [VAL_W-1:0] r_tmp, n_tmp;
    logic [VAL_W-1:0] r_res_value, n_res_value;
    logic             r_res_has, n_res_has;
    t_status          r_res_status, n_res_status;

    // output register
    logic             r_o_valid, n_o_valid;
    logic [VAL_W-1:0] r_o_value, n_o_value;
    logic             r_o_even, n_o_even;
    t_status          r_o_status, n_o_status;
    logic [CW-1:0]    r_o_occ, n_o_occ;
    logic [CW-1:0]    r_o_evc, n_o_evc;
    logic             r_o_last, n_o_last;

    // RAM port
    logic             w_we, w_re;
    logic [AW-1:0]    w_waddr, w_raddr;
    logic [VAL_W-1:0] w_wdata, w_rdata;

    logic          w_in_acc;
    logic          w_out_free;
    t_req          w_req;
    logic [CW-1:0] w_half;
    logic          w_match;

    assign w_in_acc   = i_req.valid && i_req.ready;
    assign w_out_free = !r_o_valid || o_rsp.ready;
    assign w_req      = t_req'(i_req.req_type);
    assign w_half     = r_count >> 1;
    assign w_match    = r_pend && (w_rdata == r_val);

    assign i_req.ready = (r_state == ST_IDLE);

    fwdr_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (w_req)
                        REQ_DEQ:  n_state = (r_count == '0) ? ST_RESP : ST_DQ;
                        REQ_DEL:  n_state = ST_SCAN;
                        REQ_REV:  n_state = (w_half == '0) ? ST_RESP : ST_RV_RB;
                        REQ_READ: n_state = (r_count == '0) ? ST_RESP : ST_RO_RD;
                        default:  n_state = ST_RESP;
                    endcase
                end
            end
            ST_DQ: n_state = ST_RESP;
            ST_SCAN: begin
                if (w_match) begin
                    n_state = ST_SHIFT;
                end else if (r_idx >= r_count) begin
                    n_state = ST_RESP;
                end
            end
            ST_SHIFT: begin
                if ((r_idx >= r_count) && !r_pend) begin
                    n_state = ST_RESP;
                end
            end
            ST_RV_RB: n_state = ST_RV_WA;
            ST_RV_WA: n_state = ST_RV_WB;
            ST_RV_WB: n_state = ((r_idx + CW'(1)) < w_half) ? ST_RV_RB : ST_RESP;
            ST_RO_RD: n_state = w_out_free ? ST_RO_EMIT : ST_RO_RD;
            ST_RO_EMIT: n_state = ((r_idx + CW'(1)) == r_count) ? ST_IDLE : ST_RO_RD;
            ST_RESP: n_state = w_out_free ? ST_IDLE : ST_RESP;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath, RAM port and output register
    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_even       = r_even;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_val        = r_val;
        n_tmp        = r_tmp;
        n_res_value  = r_res_value;
        n_res_has    = r_res_has;
        n_res_status = r_res_status;
        // drop the output word once it is taken
        n_o_valid    = r_o_valid && !o_rsp.ready;
        n_o_value    = r_o_value;
        n_o_even     = r_o_even;
        n_o_status   = r_o_status;
        n_o_occ      = r_o_occ;
        n_o_evc      = r_o_evc;
        n_o_last     = r_o_last;
        w_we         = 1'b0;
        w_waddr      = r_head;
        w_wdata      = r_val;
        w_re         = 1'b0;
        w_raddr      = r_head;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_val        = i_req.data_value;
                    n_idx        = '0;
                    n_pend       = 1'b0;
                    n_res_value  = '0;
                    n_res_has    = 1'b0;
                    n_res_status = STS_OK;
                    case (w_req)
                        REQ_ENQ: begin
                            if (r_count >= CW'(DEPTH)) begin
                                n_res_status = STS_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = f_slot(r_head, r_count);
                                w_wdata = i_req.data_value;
                                n_count = r_count + CW'(1);
                                if (!i_req.data_value[0]) begin
                                    n_even = r_even + CW'(1);
                                end
                            end
                        end
                        REQ_DEQ: begin
                            if (r_count == '0) begin
                                n_res_status = STS_EMPTY;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = r_head;
                            end
                        end
                        REQ_REV: begin
                            if (w_half != '0) begin
                                w_re    = 1'b1;
                                w_raddr = r_head;
                            end
                        end
                        REQ_READ: begin
                            if (r_count == '0) begin
                                n_res_status = STS_EMPTY;
                            end
                        end
                        default: begin
                            n_res_status = STS_OK;
                        end
                    endcase
                end
            end
            ST_DQ: begin
                n_res_value = w_rdata;
                n_res_has   = 1'b1;
                n_head      = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
                n_count     = r_count - CW'(1);
                if (!w_rdata[0]) begin
                    n_even = r_even - CW'(1);
                end
            end
            ST_SCAN: begin
                // on a hit r_idx already points one past the match: first source
                if (w_match) begin
                    n_pend = 1'b0;
                end else if (r_idx < r_count) begin
                    w_re    = 1'b1;
                    w_raddr = f_slot(r_head, r_idx);
                    n_idx   = r_idx + CW'(1);
                    n_pend  = 1'b1;
                end else begin
                    n_pend       = 1'b0;
                    n_res_status = STS_NOTFOUND;
                end
            end
            ST_SHIFT: begin
                // word read from r_idx-1 lands one place nearer the head
                if (r_pend) begin
                    w_we    = 1'b1;
                    w_waddr = f_slot(r_head, r_idx - CW'(2));
                    w_wdata = w_rdata;
                end
                if (r_idx < r_count) begin
                    w_re    = 1'b1;
                    w_raddr = f_slot(r_head, r_idx);
                    n_idx   = r_idx + CW'(1);
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count = r_count - CW'(1);
                        if (!r_val[0]) begin
                            n_even = r_even - CW'(1);
                        end
                    end
                end
            end
            ST_RV_RB: begin
                n_tmp   = w_rdata;
                w_re    = 1'b1;
                w_raddr = f_slot(r_head, r_count - CW'(1) - r_idx);
            end
            ST_RV_WA: begin
                w_we    = 1'b1;
                w_waddr = f_slot(r_head, r_idx);
                w_wdata = w_rdata;
            end
            ST_RV_WB: begin
                w_we    = 1'b1;
                w_waddr = f_slot(r_head, r_count - CW'(1) - r_idx);
                w_wdata = r_tmp;
                n_idx   = r_idx + CW'(1);
                if ((r_idx + CW'(1)) < w_half) begin
                    w_re    = 1'b1;
                    w_raddr = f_slot(r_head, r_idx + CW'(1));
                end
            end
            ST_RO_RD: begin
                if (w_out_free) begin
                    w_re    = 1'b1;
                    w_raddr = f_slot(r_head, r_idx);
                end
            end
            ST_RO_EMIT: begin
                n_o_valid  = 1'b1;
                n_o_value  = w_rdata;
                n_o_even   = !w_rdata[0];
                n_o_status = STS_OK;
                n_o_occ    = r_count;
                n_o_evc    = r_even;
                n_o_last   = ((r_idx + CW'(1)) == r_count);
                n_idx      = r_idx + CW'(1);
            end
            ST_RESP: begin
                if (w_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_value  = r_res_has ? r_res_value : '0;
                    n_o_even   = r_res_has && !r_res_value[0];
                    n_o_status = r_res_status;
                    n_o_occ    = r_count;
                    n_o_evc    = r_even;
                    n_o_last   = 1'b1;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_even    <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_even    <= n_even;
            r_idx     <= n_idx;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val        <= n_val;
        r_tmp        <= n_tmp;
        r_res_value  <= n_res_value;
        r_res_has    <= n_res_has;
        r_res_status <= n_res_status;
        r_o_value    <= n_o_value;
        r_o_even     <= n_o_even;
        r_o_status   <= n_o_status;
        r_o_occ      <= n_o_occ;
        r_o_evc      <= n_o_evc;
        r_o_last     <= n_o_last;
    end

    // counts are reported in five bits
    assign o_rsp.valid      = r_o_valid;
    assign o_rsp.out_value  = r_o_value;
    assign o_rsp.is_even    = r_o_even;
    assign o_rsp.status     = r_o_status;
    assign o_rsp.occupancy  = CNT_W'(r_o_occ);
    assign o_rsp.even_count = CNT_W'(r_o_evc);
    assign o_rsp.last       = r_o_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("occupancy exceeds depth");

    a_even_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_even <= r_count)
        else $error("even count exceeds occupancy");

    a_enq_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (w_req == REQ_ENQ) && (r_count < CW'(DEPTH)))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("enqueue did not advance the occupancy");

    a_even_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_even) |-> !r_o_value[0])
        else $error("even flag set on an odd word");

endmodule

`default_nettype wire

/* rtl/core/fwdr_ram.sv */
// Entry store: one write port, one read port, registered read data.
`default_nettype none

module fwdr_ram #(
    parameter int  DEPTH = fwdr_pkg::DEPTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [AW-1:0]            i_waddr,
    input  wire logic [fwdr_pkg::VAL_W-1:0] i_wdata,
    input  wire logic                     i_re,
    input  wire logic [AW-1:0]            i_raddr,
    output logic      [fwdr_pkg::VAL_W-1:0] o_rdata
);
    import fwdr_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the FIFO with delete-by-value, reverse and read-out.
`timescale 1ns / 100ps

module testbench;
    import fwdr_pkg::*;

    // Request codes that the block must ignore (no operation is defined for them).
    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

    localparam int          HALF_PERIOD = 5;
    localparam int          SETTLE_CYC  = 40;        // tail after the last result
    localparam int          PRINT_CAP   = 50;        // mismatch lines printed at most
    localparam int unsigned MAX_NS      = 5_000_000; // hard stop for the whole run

    // One expected result word, field for field as the block reports it.
    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic                    even;
        t_status                 status;
        logic [CNT_W-1:0]        occupancy;
        logic [CNT_W-1:0]        evens;
        logic                    last;
    } t_fifo_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fwdr_req_if req_bus ();
    fwdr_rsp_if rsp_bus ();

    fifo_with_delete_and_reverse #(
        .DEPTH (DEPTH_DEF)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus.sink),
        .o_rsp   (rsp_bus.source)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the queue. Updated when a request word is accepted;
    // each update appends the words the block owes for that request.
    // ------------------------------------------------------------------
    logic signed [VAL_W-1:0] queue_mem [DEPTH_DEF];
    int unsigned             head_ptr;
    int unsigned             fill_level;
    int unsigned             even_level;

    t_fifo_rsp               rsp_due [$];   // results owed by the block, oldest first
    int unsigned             mismatches;
    int unsigned             rsp_seen;

    // Sender and receiver pacing, set by the test tasks.
    int unsigned             gap_max;       // 0: offer back to back
    int unsigned             burst_left;
    logic                    req_up;
    realtime                 dropped_at;
    logic [15:0]             stall_pattern; // ready per cycle, rotated
    int unsigned             hold_len;
    int unsigned             hold_seq;

    function automatic int unsigned slot(input int unsigned k);
        return (head_ptr + k) % DEPTH_DEF;
    endfunction

    task automatic owe_result(input logic signed [VAL_W-1:0] value, input logic has_value,
                              input t_status status, input logic last);
        t_fifo_rsp w;
        w.value     = has_value ? value : '0;
        w.even      = has_value && !value[0];
        w.status    = status;
        w.occupancy = fill_level[CNT_W-1:0];
        w.evens     = even_level[CNT_W-1:0];
        w.last      = last;
        rsp_due.push_back(w);
    endtask

    // Apply one request to the shadow queue and queue up what it should produce.
    task automatic model_fifo_op(input logic [REQ_W-1:0] kind,
                                 input logic signed [VAL_W-1:0] value);
        int                      pos;
        int unsigned             k;
        logic signed [VAL_W-1:0] word;
        logic signed [VAL_W-1:0] held;
        case (kind)
            REQ_ENQ: begin
                if (fill_level >= DEPTH_DEF) begin
                    owe_result('0, 1'b0, STS_FULL, 1'b1);
                end else begin
                    queue_mem[slot(fill_level)] = value;
                    fill_level++;
                    if (!value[0]) even_level++;
                    owe_result('0, 1'b0, STS_OK, 1'b1);
                end
            end
            REQ_DEQ: begin
                if (fill_level == 0) begin
                    owe_result('0, 1'b0, STS_EMPTY, 1'b1);
                end else begin
                    word     = queue_mem[slot(0)];
                    head_ptr = (head_ptr + 1) % DEPTH_DEF;
                    fill_level--;
                    if (!word[0]) even_level--;
                    owe_result(word, 1'b1, STS_OK, 1'b1);
                end
            end
            REQ_DEL: begin
                // Find the first match from the head, then close the hole.
                pos = -1;
                for (k = 0; k < fill_level; k++) begin
                    if (pos < 0 && queue_mem[slot(k)] == value) pos = int'(k);
                end
                if (pos < 0) begin
                    owe_result('0, 1'b0, STS_NOTFOUND, 1'b1);
                end else begin
                    for (k = unsigned'(pos); k + 1 < fill_level; k++) begin
                        queue_mem[slot(k)] = queue_mem[slot(k + 1)];
                    end
                    fill_level--;
                    if (!value[0]) even_level--;
                    owe_result('0, 1'b0, STS_OK, 1'b1);
                end
            end
            REQ_REV: begin
                for (k = 0; k < fill_level / 2; k++) begin
                    held                             = queue_mem[slot(k)];
                    queue_mem[slot(k)]               = queue_mem[slot(fill_level - 1 - k)];
                    queue_mem[slot(fill_level - 1 - k)] = held;
                end
                owe_result('0, 1'b0, STS_OK, 1'b1);
            end
            REQ_READ: begin
                if (fill_level == 0) begin
                    owe_result('0, 1'b0, STS_EMPTY, 1'b1);
                end else begin
                    for (k = 0; k < fill_level; k++) begin
                        owe_result(queue_mem[slot(k)], 1'b1, STS_OK, k + 1 == fill_level);
                    end
                end
            end
            default: begin
                owe_result('0, 1'b0, STS_OK, 1'b1);
            end
        endcase
    endtask

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t: result %0d, %s: expected %0d, got %0d",
                     $realtime, rsp_seen, what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Request side: drive at the rising edge, hold until ready, then
    // advance the shadow queue. Bursts of random length with random gaps.
    // ------------------------------------------------------------------
    task automatic lower_valid();
        if (req_up) begin
            req_bus.valid <= 1'b0;
            req_up     = 1'b0;
            dropped_at = $realtime;
        end
    endtask

    task automatic send_word(input logic [REQ_W-1:0] kind,
                             input logic signed [VAL_W-1:0] value);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gap_max != 0) begin
                gap = $urandom_range(1, gap_max);
                lower_valid();
                repeat (gap) @(posedge i_clk);
            end
        end
        // Never drop and raise valid in the same step.
        if (!req_up && dropped_at == $realtime) @(posedge i_clk);
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= kind;
        req_bus.data_value <= value;
        req_up = 1'b1;
        do @(posedge i_clk); while (!req_bus.ready);
        model_fifo_op(kind, value);
        burst_left--;
    endtask

    // Pause the sender until every owed result has come back.
    task automatic wait_all_results();
        lower_valid();
        while (rsp_due.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: ready follows a rotating pattern; a hold request from a
    // test forces ready low for a counted number of cycles.
    // ------------------------------------------------------------------
    initial begin
        int unsigned hold_seen;
        int unsigned hold_left;
        logic [3:0]  pat_idx;
        hold_seen = 0;
        hold_left = 0;
        pat_idx   = '0;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= stall_pattern[pat_idx];
            end
            pat_idx++;
        end
    end

    // Compare every accepted result with the oldest owed word.
    always @(posedge i_clk) begin
        t_fifo_rsp want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            rsp_seen++;
            if (rsp_due.size() == 0) begin
                note_mismatch("result with nothing owed, out_value", 0,
                              longint'(rsp_bus.out_value));
            end else begin
                want = rsp_due.pop_front();
                if (rsp_bus.out_value !== want.value)
                    note_mismatch("out_value", longint'(want.value),
                                  longint'(rsp_bus.out_value));
                if (rsp_bus.is_even !== want.even)
                    note_mismatch("is_even", longint'(want.even),
                                  longint'(rsp_bus.is_even));
                if (rsp_bus.status !== want.status)
                    note_mismatch("status", longint'(want.status),
                                  longint'(rsp_bus.status));
                if (rsp_bus.occupancy !== want.occupancy)
                    note_mismatch("occupancy", longint'(want.occupancy),
                                  longint'(rsp_bus.occupancy));
                if (rsp_bus.even_count !== want.evens)
                    note_mismatch("even_count", longint'(want.evens),
                                  longint'(rsp_bus.even_count));
                if (rsp_bus.last !== want.last)
                    note_mismatch("last", longint'(want.last), longint'(rsp_bus.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Random content
    // ------------------------------------------------------------------
    function automatic logic signed [VAL_W-1:0] pick_stored();
        return queue_mem[slot($urandom_range(0, fill_level - 1))];
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_value();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(0, 9))
            0:          v = ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
            1, 2, 3:    v = $urandom;
            8, 9:       v = (fill_level != 0) ? pick_stored() : $urandom;
            default:    v = $signed($urandom_range(0, 31)) - 16;  // small, many repeats
        endcase
        return v;
    endfunction

    // Lean toward enqueue while the queue is short so the run visits every fill level.
    task automatic send_random_op();
        int unsigned r;
        int unsigned enq_w;
        r     = $urandom_range(0, 99);
        enq_w = (fill_level < 6) ? 55 : ((fill_level + 2 >= DEPTH_DEF) ? 20 : 35);
        if (r < enq_w)
            send_word(REQ_ENQ, rand_value());
        else if (r < enq_w + 20)
            send_word(REQ_DEQ, $urandom);
        else if (r < enq_w + 40)
            send_word(REQ_DEL, (fill_level != 0 && $urandom_range(0, 9) < 7)
                               ? pick_stored() : rand_value());
        else if (r < enq_w + 48)
            send_word(REQ_REV, $urandom);
        else if (r < 98)
            send_word(REQ_READ, $urandom);
        else
            send_word(REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)), $urandom);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every error path on an empty queue, plus the ignored request codes.
    task automatic test_empty_queue_errors();
        gap_max       = 3;
        stall_pattern = 16'($urandom) | 16'h0001;
        send_word(REQ_DEQ, $urandom);
        send_word(REQ_READ, $urandom);
        send_word(REQ_DEL, 32'h0000_0000);
        send_word(REQ_REV, $urandom);
        send_word(REQ_UNUSED_LO, $urandom);
        send_word(REQ_UNUSED_HI, $urandom);
        wait_all_results();
    endtask

    // Extreme values, negative parity, odd-length reverse and duplicate deletes.
    task automatic test_extremes_and_order();
        send_word(REQ_ENQ, 32'h7fff_ffff);
        send_word(REQ_ENQ, 32'h8000_0000);
        send_word(REQ_ENQ, -32'sd1);
        send_word(REQ_ENQ, 32'sd0);
        send_word(REQ_ENQ, -32'sd2);
        send_word(REQ_READ, $urandom);
        send_word(REQ_REV, $urandom);
        send_word(REQ_READ, $urandom);
        send_word(REQ_DEL, -32'sd1);          // middle entry, odd
        send_word(REQ_DEL, 32'sd12345);       // absent value
        send_word(REQ_DEL, 32'h7fff_ffff);    // now the tail after the reverse
        send_word(REQ_ENQ, 32'sd4);
        send_word(REQ_ENQ, 32'sd4);
        send_word(REQ_DEL, 32'sd4);           // only the first of the pair goes
        send_word(REQ_DEQ, $urandom);
        send_word(REQ_READ, $urandom);
        wait_all_results();
    endtask

    // Fill to capacity with even words, overflow, full read-out and reverse,
    // deletes at both ends, then drain past empty.
    task automatic test_fill_and_overflow();
        int unsigned k;
        gap_max       = 0;
        stall_pattern = 16'hffff;
        while (fill_level != 0) send_word(REQ_DEQ, $urandom);
        send_word(REQ_ENQ, 32'sd1);           // advance the head by one slot
        send_word(REQ_DEQ, $urandom);
        for (k = 0; k < DEPTH_DEF; k++) send_word(REQ_ENQ, $urandom & ~32'd1);
        send_word(REQ_ENQ, 32'sd7);           // full
        send_word(REQ_READ, $urandom);
        send_word(REQ_REV, $urandom);
        send_word(REQ_READ, $urandom);
        send_word(REQ_DEL, queue_mem[slot(fill_level - 1)]);
        send_word(REQ_DEL, queue_mem[slot(0)]);
        send_word(REQ_ENQ, 32'sd3);
        send_word(REQ_READ, $urandom);
        while (fill_level != 0) send_word(REQ_DEQ, $urandom);
        send_word(REQ_DEQ, $urandom);
        wait_all_results();
    endtask

    // Hold ready low for a long stretch while requests keep coming, so the
    // output register fills and the input backs up.
    task automatic test_output_backpressure();
        int unsigned k;
        gap_max       = 0;
        stall_pattern = 16'hffff;
        hold_len      = 300;
        hold_seq++;
        for (k = 0; k < 8; k++) send_word(REQ_ENQ, rand_value());
        send_word(REQ_READ, $urandom);
        send_word(REQ_REV, $urandom);
        send_word(REQ_READ, $urandom);
        send_word(REQ_DEQ, $urandom);
        send_word(REQ_DEL, pick_stored());
        wait_all_results();
    endtask

    // Random traffic under three pacing regimes.
    task automatic test_random_traffic();
        int unsigned pass;
        int unsigned k;
        for (pass = 0; pass < 3; pass++) begin
            case (pass)
                0: begin
                    gap_max       = 0;
                    stall_pattern = 16'hffff;
                end
                1: begin
                    gap_max       = 6;
                    stall_pattern = 16'($urandom) | 16'h0001;
                end
                default: begin
                    gap_max       = 2;
                    stall_pattern = 16'($urandom & $urandom) | 16'h0100;
                end
            endcase
            for (k = 0; k < 33; k++) send_random_op();
            wait_all_results();
        end
    endtask

    // Hard stop in case the block hangs.
    initial begin
        #(MAX_NS);
        $display("fifo_with_delete_and_reverse regression: fail");
        $finish;
    end

    initial begin
        i_rst_n            <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.req_type   <= REQ_ENQ;
        req_bus.data_value <= '0;
        head_ptr      = 0;
        fill_level    = 0;
        even_level    = 0;
        mismatches    = 0;
        rsp_seen      = 0;
        gap_max       = 0;
        burst_left    = 0;
        req_up        = 1'b0;
        dropped_at    = -1.0;
        stall_pattern = 16'hffff;
        hold_len      = 0;
        hold_seq      = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue_errors();
        test_extremes_and_order();
        test_fill_and_overflow();
        test_output_backpressure();
        test_random_traffic();

        wait_all_results();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (mismatches == 0 && rsp_due.size() == 0)
            $display("fifo_with_delete_and_reverse regression: pass");
        else
            $display("fifo_with_delete_and_reverse regression: fail");
        $finish;
    end

endmodule

/* files.f */
rtl/core/fwdr_pkg.sv
rtl/core/fwdr_if.sv
rtl/core/fwdr_ram.sv
rtl/core/fifo_with_delete_and_reverse.sv
tb/sv/testbench.sv
